/* rtl/mcpw_pkg.sv */
`timescale 1ns / 1ps

package mcpw_pkg;

    localparam int COORD_BITS  = 12;
    localparam int MAX_RADIUS  = 88;
    localparam int MAX_STEPS   = 64;
    localparam int RAD_BITS    = 7;
    localparam int COLOR_BITS  = 24;
    localparam int ADDR_BITS   = 32;
    localparam int DATA_BITS   = 32;
    localparam int STRIDE_BITS = 14;
    localparam int FMT_BITS    = 2;
    localparam int SCREEN_BITS = 13;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;
    localparam int MASK_BITS   = 8;
    localparam int PIX_IDX_BITS = $clog2(MASK_BITS);

    localparam int STEP_BITS  = $clog2(MAX_RADIUS + 1);
    localparam int DEC_BITS   = STEP_BITS + 4;
    localparam int COUNT_BITS = $clog2(MAX_STEPS + 1);
    // signed pixel position: center plus or minus an offset
    localparam int POS_BITS   = COORD_BITS + 2;
    localparam int CMP_BITS   = (POS_BITS - 1 > SCREEN_BITS) ? POS_BITS - 1 : SCREEN_BITS;
    localparam int PROD_BITS  = POS_BITS - 1 + STRIDE_BITS;

    localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET    = STRIDE_BITS'(1920);
    localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = SCREEN_BITS'(480);
    localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = SCREEN_BITS'(272);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_BASE    = 3'd0,
        REG_ROW_STRIDE    = 3'd1,
        REG_PIXEL_FORMAT  = 3'd2,
        REG_SCREEN_WIDTH  = 3'd3,
        REG_SCREEN_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic [FMT_BITS-1:0] {
        FMT_8BPP   = 2'd0,
        FMT_RGB565 = 2'd1,
        FMT_32BPP  = 2'd2
    } pixel_fmt_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_PIX  = 4'b0100,
        ST_SEND = 4'b1000
    } state_t;

    function automatic logic [DATA_BITS-1:0] format_color(
        input logic [FMT_BITS-1:0]   fmt,
        input logic [COLOR_BITS-1:0] color
    );
        logic [DATA_BITS-1:0] result;
        begin
            unique case (fmt)
                FMT_8BPP:   result = DATA_BITS'(color[7:0]);
                FMT_RGB565: result = DATA_BITS'({color[23:19], color[15:10], color[7:3]});
                default:    result = DATA_BITS'(color);
            endcase
            return result;
        end
    endfunction

    // log2 of bytes per pixel, unused code behaves as 32 bpp
    function automatic logic [1:0] bpp_shift(input logic [FMT_BITS-1:0] fmt);
        logic [1:0] result;
        begin
            unique case (fmt)
                FMT_8BPP:   result = 2'd0;
                FMT_RGB565: result = 2'd1;
                default:    result = 2'd2;
            endcase
            return result;
        end
    endfunction

endpackage

/* rtl/mcpw_cmd_if.sv */
`timescale 1ns / 1ps

interface mcpw_cmd_if import mcpw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [RAD_BITS-1:0]   radius;
    logic [COLOR_BITS-1:0] color;

    modport source (output valid, center_x, center_y, radius, color, input ready);
    modport sink   (input valid, center_x, center_y, radius, color, output ready);
endinterface

/* rtl/mcpw_res_if.sv */
`timescale 1ns / 1ps

interface mcpw_res_if import mcpw_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ADDR_BITS-1:0] addr_0;
    logic [ADDR_BITS-1:0] addr_1;
    logic [ADDR_BITS-1:0] addr_2;
    logic [ADDR_BITS-1:0] addr_3;
    logic [ADDR_BITS-1:0] addr_4;
    logic [ADDR_BITS-1:0] addr_5;
    logic [ADDR_BITS-1:0] addr_6;
    logic [ADDR_BITS-1:0] addr_7;
    logic [DATA_BITS-1:0] pixel_data;
    logic [MASK_BITS-1:0] offscreen_mask;
    logic                 last_step;

    modport source (output valid, addr_0, addr_1, addr_2, addr_3, addr_4, addr_5, addr_6,
                    addr_7, pixel_data, offscreen_mask, last_step, input ready);
    modport sink   (input valid, addr_0, addr_1, addr_2, addr_3, addr_4, addr_5, addr_6,
                    addr_7, pixel_data, offscreen_mask, last_step, output ready);
endinterface

/* rtl/mcpw_cfg_if.sv */
`timescale 1ns / 1ps

interface mcpw_cfg_if import mcpw_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/midpoint_circle_pixel_writer.sv */
`timescale 1ns / 1ps

// channel  dir  word                                          
// cmd      in   center_x, center_y, radius, color             
// res      out  addr_0..addr_7, pixel_data, offscreen_mask, last_step
// cfg      in   index, data (register write, always ready)    
//
// each step of the circle is a step update, after which the single address unit
// (one multiplier and its adders) forms the 8 mirrored pixels one after another
// a circle has at most 64 steps and gives one word per step
// cmd is ready only while idle; a command with zero radius gives no word
// the last word waits in the output register while the next command is taken
// rst_n clears the sequencer, output valid and the configuration registers to their defaults

module midpoint_circle_pixel_writer import mcpw_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    mcpw_cmd_if.sink  cmd,
    mcpw_res_if.source res,
    mcpw_cfg_if.sink  cfg
);

    // configuration
    logic [ADDR_BITS-1:0]   frame_base_reg;
    logic [STRIDE_BITS-1:0] row_stride_reg;
    logic [FMT_BITS-1:0]    pixel_format_reg;
    logic [SCREEN_BITS-1:0] screen_width_reg;
    logic [SCREEN_BITS-1:0] screen_height_reg;

    // sequencer and iteration state
    state_t                       state_reg, state_next;
    logic [STEP_BITS-1:0]         x_reg, x_next;
    logic [STEP_BITS-1:0]         y_reg, y_next;
    logic signed [DEC_BITS-1:0]   dec_reg, dec_next;
    logic [COUNT_BITS-1:0]        count_reg, count_next;
    logic                         last_reg, last_next;
    logic [PIX_IDX_BITS-1:0]      k_reg, k_next;
    logic                         out_valid_reg, out_valid_next;

    // held command and work results
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [DATA_BITS-1:0]  data_reg;
    logic [ADDR_BITS-1:0]  addr_work_reg [MASK_BITS];
    logic [MASK_BITS-1:0]  mask_work_reg;

    // output register
    logic [ADDR_BITS-1:0]  out_addr_reg [MASK_BITS];
    logic [DATA_BITS-1:0]  out_data_reg;
    logic [MASK_BITS-1:0]  out_mask_reg;
    logic                  out_last_reg;

    logic                  cmd_fire;
    logic                  out_load;
    logic                  do_step;
    logic [RAD_BITS-1:0]   radius_sat;

    // step unit
    logic signed [DEC_BITS-1:0] x_ext, y_ext, dec_step;
    logic [STEP_BITS-1:0]       x_step, y_step;
    logic [COUNT_BITS-1:0]      count_step;
    logic                       last_step_calc;

    // address unit
    logic [STEP_BITS-1:0]       col_mag, row_mag;
    logic signed [POS_BITS-1:0] col_pos, row_pos;
    logic [PROD_BITS-1:0]       row_prod;
    logic [ADDR_BITS-1:0]       col_off, pix_addr;
    logic                       pix_clip;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign out_load  = (state_reg == ST_SEND) && (!out_valid_reg || res.ready);
    assign do_step   = (state_reg == ST_STEP) || (out_load && !last_reg);

    assign radius_sat = (cmd.radius > RAD_BITS'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                             : cmd.radius;

    // midpoint update: x always advances, y drops when the decision is nonnegative
    always_comb
    begin
        x_ext  = DEC_BITS'(x_reg);
        y_ext  = DEC_BITS'(y_reg);
        x_step = x_reg + STEP_BITS'(1);
        if (!dec_reg[DEC_BITS-1])
        begin
            dec_step = dec_reg + ((x_ext - y_ext) <<< 1) + DEC_BITS'(5);
            y_step   = y_reg - STEP_BITS'(1);
        end
        else
        begin
            dec_step = dec_reg + (x_ext <<< 1) + DEC_BITS'(3);
            y_step   = y_reg;
        end
        count_step     = count_reg + COUNT_BITS'(1);
        last_step_calc = (x_step >= y_step) || (count_step == COUNT_BITS'(MAX_STEPS));
    end

    // pixel k: bit 1 swaps the offsets, bit 0 negates the column, bit 2 the row
    always_comb
    begin
        col_mag  = k_reg[1] ? y_reg : x_reg;
        row_mag  = k_reg[1] ? x_reg : y_reg;
        col_pos  = k_reg[0] ? POS_BITS'(cx_reg) - POS_BITS'(col_mag)
                            : POS_BITS'(cx_reg) + POS_BITS'(col_mag);
        row_pos  = k_reg[2] ? POS_BITS'(cy_reg) - POS_BITS'(row_mag)
                            : POS_BITS'(cy_reg) + POS_BITS'(row_mag);
        pix_clip = col_pos[POS_BITS-1] || row_pos[POS_BITS-1]
                   || (CMP_BITS'(col_pos[POS_BITS-2:0]) >= CMP_BITS'(screen_width_reg))
                   || (CMP_BITS'(row_pos[POS_BITS-2:0]) >= CMP_BITS'(screen_height_reg));
        row_prod = PROD_BITS'(row_pos[POS_BITS-2:0]) * PROD_BITS'(row_stride_reg);
        col_off  = ADDR_BITS'(col_pos[POS_BITS-2:0]) << bpp_shift(pixel_format_reg);
        pix_addr = frame_base_reg + ADDR_BITS'(row_prod) + col_off;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        dec_next       = dec_reg;
        count_next     = count_reg;
        last_next      = last_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;

        if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end

        if (do_step)
        begin
            x_next     = x_step;
            y_next     = y_step;
            dec_next   = dec_step;
            count_next = count_step;
            last_next  = last_step_calc;
            k_next     = '0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (radius_sat != '0))
                begin
                    x_next     = '0;
                    y_next     = STEP_BITS'(radius_sat);
                    dec_next   = DEC_BITS'(1) - DEC_BITS'(radius_sat);
                    count_next = '0;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                state_next = ST_PIX;
            end
            ST_PIX:
            begin
                k_next = k_reg + PIX_IDX_BITS'(1);
                if (k_reg == PIX_IDX_BITS'(MASK_BITS - 1))
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_load)
                begin
                    state_next = last_reg ? ST_IDLE : ST_PIX;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            x_reg             <= '0;
            y_reg             <= '0;
            dec_reg           <= '0;
            count_reg         <= '0;
            last_reg          <= 1'b0;
            k_reg             <= '0;
            out_valid_reg     <= 1'b0;
            frame_base_reg    <= '0;
            row_stride_reg    <= ROW_STRIDE_RESET;
            pixel_format_reg  <= FMT_32BPP;
            screen_width_reg  <= SCREEN_WIDTH_RESET;
            screen_height_reg <= SCREEN_HEIGHT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            dec_reg       <= dec_next;
            count_reg     <= count_next;
            last_reg      <= last_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    REG_FRAME_BASE:    frame_base_reg    <= ADDR_BITS'(cfg.data);
                    REG_ROW_STRIDE:    row_stride_reg    <= cfg.data[STRIDE_BITS-1:0];
                    REG_PIXEL_FORMAT:  pixel_format_reg  <= cfg.data[FMT_BITS-1:0];
                    REG_SCREEN_WIDTH:  screen_width_reg  <= cfg.data[SCREEN_BITS-1:0];
                    REG_SCREEN_HEIGHT: screen_height_reg <= cfg.data[SCREEN_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cx_reg   <= cmd.center_x;
            cy_reg   <= cmd.center_y;
            data_reg <= format_color(pixel_format_reg, cmd.color);
        end
        if (state_reg == ST_PIX)
        begin
            addr_work_reg[k_reg] <= pix_clip ? '0 : pix_addr;
            mask_work_reg[k_reg] <= pix_clip;
        end
        if (out_load)
        begin
            out_addr_reg <= addr_work_reg;
            out_mask_reg <= mask_work_reg;
            out_data_reg <= data_reg;
            out_last_reg <= last_reg;
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.addr_0         = out_addr_reg[0];
    assign res.addr_1         = out_addr_reg[1];
    assign res.addr_2         = out_addr_reg[2];
    assign res.addr_3         = out_addr_reg[3];
    assign res.addr_4         = out_addr_reg[4];
    assign res.addr_5         = out_addr_reg[5];
    assign res.addr_6         = out_addr_reg[6];
    assign res.addr_7         = out_addr_reg[7];
    assign res.pixel_data     = out_data_reg;
    assign res.offscreen_mask = out_mask_reg;
    assign res.last_step      = out_last_reg;

endmodule

/* rtl/mcpw_checker.sv */
`timescale 1ns / 1ps

module mcpw_checker import mcpw_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic [RAD_BITS-1:0]   cmd_radius,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic [ADDR_BITS-1:0]  res_addr_0,
    input logic [ADDR_BITS-1:0]  res_addr_1,
    input logic [ADDR_BITS-1:0]  res_addr_2,
    input logic [ADDR_BITS-1:0]  res_addr_3,
    input logic [ADDR_BITS-1:0]  res_addr_4,
    input logic [ADDR_BITS-1:0]  res_addr_5,
    input logic [ADDR_BITS-1:0]  res_addr_6,
    input logic [ADDR_BITS-1:0]  res_addr_7,
    input logic [MASK_BITS-1:0]  res_mask,
    input logic                  res_last
);

    // a circle with nonzero radius keeps the block busy
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready && (cmd_radius != '0) |=> !cmd_ready)
        else $error("command port ready right after a circle was taken");

    // when idle, a word still waiting must be the end of the previous circle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready && res_valid |-> res_last)
        else $error("idle while a non-final word is pending");

    // clipped pixels carry a zero address
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res_mask[0] || res_addr_0 == '0) && (!res_mask[1] || res_addr_1 == '0)
                   && (!res_mask[2] || res_addr_2 == '0) && (!res_mask[3] || res_addr_3 == '0)
                   && (!res_mask[4] || res_addr_4 == '0) && (!res_mask[5] || res_addr_5 == '0)
                   && (!res_mask[6] || res_addr_6 == '0) && (!res_mask[7] || res_addr_7 == '0))
        else $error("clipped pixel with nonzero address");

    // a stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_addr_0) && $stable(res_mask)
                                   && $stable(res_last))
        else $error("result word changed while stalled");

endmodule

bind midpoint_circle_pixel_writer mcpw_checker u_mcpw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .cmd_radius (cmd.radius),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .res_addr_0 (res.addr_0),
    .res_addr_1 (res.addr_1),
    .res_addr_2 (res.addr_2),
    .res_addr_3 (res.addr_3),
    .res_addr_4 (res.addr_4),
    .res_addr_5 (res.addr_5),
    .res_addr_6 (res.addr_6),
    .res_addr_7 (res.addr_7),
    .res_mask   (res.offscreen_mask),
    .res_last   (res.last_step)
);
